### sv/lrusr_pkg.sv
// Shared types and constants for the LRU set replacement unit.
package lrusr_pkg;

  localparam int unsigned ACC_TAG_W = 32;
  localparam int unsigned HIT_POS_W = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CNT_W     = 32;

  typedef logic [KIND_W-1:0] evict_kind_t;

  localparam evict_kind_t EVICT_NONE      = 2'd0;
  localparam evict_kind_t EVICT_SILENT    = 2'd1;
  localparam evict_kind_t EVICT_WRITEBACK = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

### sv/lrusr_if.sv
// Valid/ready channel interfaces for access requests and access results.
interface lrusr_in_if;
  logic                            valid;
  logic                            ready;
  logic [lrusr_pkg::ACC_TAG_W-1:0] access_tag;
  logic                            operation;

  modport source (output valid, output access_tag, output operation, input ready);
  modport sink (input valid, input access_tag, input operation, output ready);
endinterface

interface lrusr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [lrusr_pkg::HIT_POS_W-1:0] hit_position;
  logic [lrusr_pkg::KIND_W-1:0]    evict_kind;
  logic [lrusr_pkg::CNT_W-1:0]     hits_total;
  logic [lrusr_pkg::CNT_W-1:0]     misses_total;
  logic [lrusr_pkg::CNT_W-1:0]     writebacks_total;
  logic [lrusr_pkg::CNT_W-1:0]     silent_total;

  modport source (output valid, output hit, output hit_position, output evict_kind,
                  output hits_total, output misses_total, output writebacks_total,
                  output silent_total, input ready);
  modport sink (input valid, input hit, input hit_position, input evict_kind,
                input hits_total, input misses_total, input writebacks_total,
                input silent_total, output ready);
endinterface

### sv/lru_set_replacement_unit.sv
// Top level of the true-LRU replacement unit for one cache set.
//
// The in_chan channel carries one access word: a tag and a read/write flag.
// The out_chan channel returns one result word per access: hit flag, recency
// position of the hit, eviction kind and the four running counters.
// Both channels use valid/ready; a word moves when both are high.
// An access passes through the accept step, in which it is captured, the
// parallel tag compare over all WAYS entries, and the commit step, which
// shifts the recency order, updates the counters and loads the result
// register, from which its result word is presented.
// The next access is accepted in the cycle after the previous one commits,
// so a new access is not taken before the last one has committed.
// The result register lets a new access be accepted and searched while the
// previous result waits; if out_chan stalls, the commit step holds until
// the result register frees, and the set state does not change meanwhile.
// Synchronous reset (rst_n low) empties the set, clears all counters and
// drops out_chan.valid; no clearing pass is needed.
module lru_set_replacement_unit #(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  lrusr_in_if.sink    in_chan,
  lrusr_out_if.source out_chan
);
  import lrusr_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lrusr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrusr_dp #(
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_access_tag        (in_chan.access_tag),
    .in_operation         (in_chan.operation),
    .out_valid            (out_chan.valid),
    .out_ready            (out_chan.ready),
    .out_hit              (out_chan.hit),
    .out_hit_position     (out_chan.hit_position),
    .out_evict_kind       (out_chan.evict_kind),
    .out_hits_total       (out_chan.hits_total),
    .out_misses_total     (out_chan.misses_total),
    .out_writebacks_total (out_chan.writebacks_total),
    .out_silent_total     (out_chan.silent_total)
  );

endmodule

### sv/lrusr_ctrl.sv
// Sequencing state machine for the LRU set replacement unit.
module lrusr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lrusr_pkg::ctrl_sts_t sts,
  output lrusr_pkg::ctrl_cmd_t cmd
);
  import lrusr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_load_to_search: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SEARCH)
    else $error("accepted word did not start a search");

  a_search_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search |=> state_r == ST_COMMIT)
    else $error("search was not followed by commit");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == ST_IDLE && in_ready)
    else $error("commit did not return to idle");

endmodule

### sv/lrusr_dp.sv
// Tag store, recency shifter, counters and result register of the LRU unit.
module lrusr_dp #(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrusr_pkg::ctrl_cmd_t              cmd,
  output lrusr_pkg::ctrl_sts_t              sts,
  input  logic [lrusr_pkg::ACC_TAG_W-1:0]   in_access_tag,
  input  logic                              in_operation,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [lrusr_pkg::HIT_POS_W-1:0]   out_hit_position,
  output logic [lrusr_pkg::KIND_W-1:0]      out_evict_kind,
  output logic [lrusr_pkg::CNT_W-1:0]       out_hits_total,
  output logic [lrusr_pkg::CNT_W-1:0]       out_misses_total,
  output logic [lrusr_pkg::CNT_W-1:0]       out_writebacks_total,
  output logic [lrusr_pkg::CNT_W-1:0]       out_silent_total
);
  import lrusr_pkg::*;

  localparam int unsigned POS_W = $clog2(WAYS);

  logic [TAG_BITS-1:0] entry_tag_r [WAYS];
  logic [WAYS-1:0]     entry_valid_r;
  logic [WAYS-1:0]     entry_dirty_r;

  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] wb_cnt_r;
  logic [CNT_W-1:0] silent_cnt_r;

  logic [TAG_BITS-1:0] req_tag_r;
  logic                req_wr_r;

  logic              found_r;
  logic [POS_W-1:0]  shpos_r;
  evict_kind_t       kind_r;
  logic              new_dirty_r;

  logic              found_nxt;
  logic [POS_W-1:0]  hit_idx;
  logic [POS_W-1:0]  empty_idx;
  logic              full;
  logic [POS_W-1:0]  shpos_nxt;
  evict_kind_t       kind_nxt;
  logic              new_dirty_nxt;

  logic [CNT_W-1:0]  hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_nxt;
  logic [CNT_W-1:0]  wb_cnt_nxt;
  logic [CNT_W-1:0]  silent_cnt_nxt;
  logic [POS_W+HIT_POS_W-1:0] hpos_wide;

  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_tag_r <= TAG_BITS'(in_access_tag);
      req_wr_r  <= in_operation;
    end
  end

  always_comb begin
    found_nxt = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    full      = &entry_valid_r;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (entry_valid_r[i] && entry_tag_r[i] == req_tag_r) begin
        found_nxt = 1'b1;
        hit_idx   = POS_W'(i);
      end
      if (!entry_valid_r[i]) begin
        empty_idx = POS_W'(i);
      end
    end
    kind_nxt      = EVICT_NONE;
    new_dirty_nxt = req_wr_r;
    if (found_nxt) begin
      shpos_nxt     = hit_idx;
      new_dirty_nxt = entry_dirty_r[hit_idx] | req_wr_r;
    end else if (!full) begin
      shpos_nxt = empty_idx;
    end else begin
      shpos_nxt = POS_W'(WAYS - 1);
      kind_nxt  = entry_dirty_r[WAYS-1] ? EVICT_WRITEBACK : EVICT_SILENT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      found_r     <= found_nxt;
      shpos_r     <= shpos_nxt;
      kind_r      <= kind_nxt;
      new_dirty_r <= new_dirty_nxt;
    end
  end

  always_comb begin
    hit_cnt_nxt    = hit_cnt_r + CNT_W'(found_r);
    miss_cnt_nxt   = miss_cnt_r + CNT_W'(!found_r);
    wb_cnt_nxt     = wb_cnt_r + CNT_W'(kind_r == EVICT_WRITEBACK);
    silent_cnt_nxt = silent_cnt_r + CNT_W'(kind_r == EVICT_SILENT);
    hpos_wide      = {{HIT_POS_W{1'b0}}, shpos_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      wb_cnt_r      <= '0;
      silent_cnt_r  <= '0;
    end else if (cmd.commit) begin
      for (int i = 1; i < WAYS; i++) begin
        if (POS_W'(i) <= shpos_r) begin
          entry_valid_r[i] <= entry_valid_r[i-1];
        end
      end
      entry_valid_r[0] <= 1'b1;
      hit_cnt_r        <= hit_cnt_nxt;
      miss_cnt_r       <= miss_cnt_nxt;
      wb_cnt_r         <= wb_cnt_nxt;
      silent_cnt_r     <= silent_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 1; i < WAYS; i++) begin
        if (POS_W'(i) <= shpos_r) begin
          entry_tag_r[i]   <= entry_tag_r[i-1];
          entry_dirty_r[i] <= entry_dirty_r[i-1];
        end
      end
      entry_tag_r[0]   <= req_tag_r;
      entry_dirty_r[0] <= new_dirty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit              <= found_r;
      out_hit_position     <= found_r ? hpos_wide[HIT_POS_W-1:0] : '0;
      out_evict_kind       <= kind_r;
      out_hits_total       <= hit_cnt_nxt;
      out_misses_total     <= miss_cnt_nxt;
      out_writebacks_total <= wb_cnt_nxt;
      out_silent_total     <= silent_cnt_nxt;
    end
  end

  a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result word was not presented");

  a_front_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> entry_valid_r[0])
    else $error("front entry invalid after an access");

endmodule

### bench/lru_set_replacement_unit_test.sv
// Self-checking testbench for the true-LRU cache set replacement unit.
module lru_set_replacement_unit_test;
  import lrusr_pkg::*;

  localparam int SET_WAYS     = 8;
  localparam int SET_TAG_BITS = 32;
  localparam int RANDOM_WORDS = 1630;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic                 hit;
    logic [HIT_POS_W-1:0] hit_position;
    evict_kind_t          evict_kind;
    logic [CNT_W-1:0]     hits_total;
    logic [CNT_W-1:0]     misses_total;
    logic [CNT_W-1:0]     writebacks_total;
    logic [CNT_W-1:0]     silent_total;
  } access_result_t;

  class replacement_scoreboard;
    logic [ACC_TAG_W-1:0] line_tag[SET_WAYS];
    bit                   line_valid[SET_WAYS];
    bit                   line_dirty[SET_WAYS];
    logic [CNT_W-1:0]     hit_tally;
    logic [CNT_W-1:0]     miss_tally;
    logic [CNT_W-1:0]     writeback_count;
    logic [CNT_W-1:0]     silent_count;
    access_result_t       pending_results[$];
    int                   mismatches;

    function new();
      for (int i = 0; i < SET_WAYS; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
      end
      hit_tally       = '0;
      miss_tally      = '0;
      writeback_count = '0;
      silent_count    = '0;
      mismatches      = 0;
    endfunction

    task report(string msg);
      if (mismatches < 40) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
      mismatches++;
    endtask

    function void note_access(logic [ACC_TAG_W-1:0] tag, logic write_op);
      access_result_t r;
      int             pos;
      int             free_pos;
      int             last;
      bit             found;
      bit             dirty;
      found    = 1'b0;
      pos      = 0;
      free_pos = SET_WAYS;
      r        = '0;
      for (int i = 0; i < SET_WAYS; i++) begin
        if (!found && line_valid[i] && line_tag[i] == tag) begin
          found = 1'b1;
          pos   = i;
        end
        if (free_pos == SET_WAYS && !line_valid[i]) begin
          free_pos = i;
        end
      end
      r.evict_kind = EVICT_NONE;
      if (found) begin
        hit_tally++;
        dirty          = line_dirty[pos] | write_op;
        last           = pos;
        r.hit          = 1'b1;
        r.hit_position = pos[HIT_POS_W-1:0];
      end else begin
        miss_tally++;
        dirty = write_op;
        if (free_pos < SET_WAYS) begin
          last = free_pos;
        end else begin
          last = SET_WAYS - 1;
          if (line_dirty[last]) begin
            writeback_count++;
            r.evict_kind = EVICT_WRITEBACK;
          end else begin
            silent_count++;
            r.evict_kind = EVICT_SILENT;
          end
        end
      end
      for (int i = last; i > 0; i--) begin
        line_tag[i]   = line_tag[i-1];
        line_valid[i] = line_valid[i-1];
        line_dirty[i] = line_dirty[i-1];
      end
      line_tag[0]        = tag;
      line_valid[0]      = 1'b1;
      line_dirty[0]      = dirty;
      r.hits_total       = hit_tally;
      r.misses_total     = miss_tally;
      r.writebacks_total = writeback_count;
      r.silent_total     = silent_count;
      pending_results.push_back(r);
    endfunction

    task compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h expected %0h", name, got, want));
      end
    endtask

    task check_result(access_result_t got);
      access_result_t want;
      if (pending_results.size() == 0) begin
        report("result word with no access pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("hit", got.hit, want.hit);
        compare_field("hit_position", got.hit_position, want.hit_position);
        compare_field("evict_kind", got.evict_kind, want.evict_kind);
        compare_field("hits_total", got.hits_total, want.hits_total);
        compare_field("misses_total", got.misses_total, want.misses_total);
        compare_field("writebacks_total", got.writebacks_total, want.writebacks_total);
        compare_field("silent_total", got.silent_total, want.silent_total);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  bit   sender_steady;
  bit   receiver_steady;

  replacement_scoreboard lru_board;

  lrusr_in_if  in_chan();
  lrusr_out_if out_chan();

  lru_set_replacement_unit #(
    .WAYS    (SET_WAYS),
    .TAG_BITS(SET_TAG_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lru_set_replacement_unit_test NOT OK");
      $finish;
    end
  end

  task automatic send_access(input logic [ACC_TAG_W-1:0] tag, input logic write_op);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.access_tag <= tag;
    in_chan.operation  <= write_op;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    lru_board.note_access(tag, write_op);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (lru_board.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hA5A5_A5A5, 1'b1);
    send_access(32'h5A5A_5A5A, 1'b0);
    send_access(32'h0000_0001, 1'b0);
    send_access(32'h0000_0002, 1'b1);
    send_access(32'h8000_0000, 1'b0);
    send_access(32'h7FFF_FFFF, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0000, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'h0000_0003, 1'b0);
    send_access(32'h0000_0004, 1'b0);
    send_access(32'h0000_0005, 1'b1);
    send_access(32'h0000_0006, 1'b0);
    send_access(32'h0000_0007, 1'b0);
    send_access(32'h0000_0008, 1'b0);
    send_access(32'h0000_0009, 1'b0);
    send_access(32'h0000_000A, 1'b0);
    send_access(32'h0000_000B, 1'b0);
    send_access(32'h0000_000C, 1'b0);
    drain_results();
  endtask

  task automatic run_random();
    logic [ACC_TAG_W-1:0] tag_pool[16];
    logic [ACC_TAG_W-1:0] tag;
    int                   pool_size;
    int                   pick;
    pool_size = 8;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 120 == 0) begin
        pool_size = $urandom_range(6, 16);
        for (int i = 0; i < 16; i++) begin
          tag_pool[i] = $urandom;
        end
      end
      if (k % 200 == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      if (k == RANDOM_WORDS / 2) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        tag = tag_pool[$urandom_range(0, pool_size - 1)];
      end else if (pick < 88) begin
        tag = tag_pool[$urandom_range(0, pool_size - 1)] ^ (32'h1 << $urandom_range(0, 31));
      end else if (pick < 96) begin
        tag = $urandom;
      end else begin
        tag = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      end
      send_access(tag, 1'($urandom_range(0, 1)));
    end
    in_chan.valid <= 1'b0;
  endtask

  initial begin
    int results_seen;
    int gap;
    access_result_t got;
    results_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen % 150 == 0) begin
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      if (results_seen == 500) begin
        gap = HOLD_CYCLES;
      end else begin
        gap = receiver_steady ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      got.hit              = out_chan.hit;
      got.hit_position     = out_chan.hit_position;
      got.evict_kind       = out_chan.evict_kind;
      got.hits_total       = out_chan.hits_total;
      got.misses_total     = out_chan.misses_total;
      got.writebacks_total = out_chan.writebacks_total;
      got.silent_total     = out_chan.silent_total;
      lru_board.check_result(got);
      results_seen++;
    end
  end

  initial begin
    lru_board          = new();
    sender_steady      = 1'b0;
    receiver_steady    = 1'b0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.access_tag <= '0;
    in_chan.operation  <= 1'b0;
    out_chan.ready     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    while (lru_board.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (lru_board.mismatches == 0 && lru_board.pending_results.size() == 0) begin
      $display("lru_set_replacement_unit_test OK");
    end else begin
      $display("lru_set_replacement_unit_test NOT OK");
    end
    $finish;
  end

endmodule
